@@ design/swts_pkg.sv @@
package swts_pkg;

    // Default array geometry and frame counter range
    localparam int unsigned WINDOW_FRAMES_DEF       = 100;
    localparam int unsigned MAX_TICKS_PER_FRAME_DEF = 20;
    localparam int unsigned FRAME_MODULUS_DEF       = 1024;

    // Fixed field widths
    localparam int unsigned FRAME_W  = 10;
    localparam int unsigned TICK_W   = 5;
    localparam int unsigned AMOUNT_W = 32;
    localparam int unsigned SUM_W    = 48;
    localparam int unsigned CFG_W    = 5;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned S_DATA_W = 48;
    localparam int unsigned TPF_W    = 6;

    localparam int unsigned TPF_RESET = 10;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_TICK_REPORTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DATA_ADDED    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DATA_DROPPED  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TICK_REJECTED = 2'd3;

    typedef struct packed {
        logic latch_in;
        logic clear_step;
        logic load_result;
        logic rd_cur;
        logic rd_next;
        logic data_wr;
        logic step_wr;
    } swts_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic is_data;
        logic pos_match;
        logic tick_valid;
        logic out_free;
    } swts_sts_t;

    // Clamp ticks per frame into 1..max_tpf
    function automatic logic [TPF_W-1:0] sat_tpf(input logic [CFG_W-1:0] v,
                                                 input int unsigned max_tpf);
        logic [TPF_W-1:0] r;
        r = {1'b0, v};
        if (r == '0) begin
            r = TPF_W'(1);
        end else if (int'(r) > int'(max_tpf)) begin
            r = TPF_W'(max_tpf);
        end
        return r;
    endfunction

endpackage

@@ design/swts_ctrl.sv @@
module swts_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                cfg_wr_en,
    input  swts_pkg::swts_sts_t sts,
    output swts_pkg::swts_cmd_t cmd,
    output logic                s_tready
);
    import swts_pkg::*;

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_EVAL    = 3'd2;
    localparam logic [2:0] S_DATA_WR = 3'd3;
    localparam logic [2:0] S_STEP_RD = 3'd4;
    localparam logic [2:0] S_STEP_WR = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (sts.clear_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready     = 1'b1;
                cmd.latch_in = s_tvalid;
                if (s_tvalid) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                // hold until the result register can take the word
                if (sts.out_free) begin
                    cmd.load_result = 1'b1;
                    if (sts.is_data && sts.pos_match) begin
                        cmd.rd_cur = 1'b1;
                        state_next = S_DATA_WR;
                    end else if (!sts.is_data && sts.tick_valid) begin
                        state_next = S_STEP_RD;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_DATA_WR: begin
                cmd.data_wr = 1'b1;
                state_next  = S_IDLE;
            end
            S_STEP_RD: begin
                if (sts.pos_match) begin
                    state_next = S_IDLE;
                end else begin
                    cmd.rd_next = 1'b1;
                    state_next  = S_STEP_WR;
                end
            end
            S_STEP_WR: begin
                cmd.step_wr = 1'b1;
                state_next  = S_STEP_RD;
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
        // a register write restarts the window
        if (cfg_wr_en) begin
            state_next = S_CLEAR;
        end
    end

endmodule

@@ design/swts_datapath.sv @@
module swts_datapath #(
    parameter int unsigned WINDOW_FRAMES       = swts_pkg::WINDOW_FRAMES_DEF,
    parameter int unsigned MAX_TICKS_PER_FRAME = swts_pkg::MAX_TICKS_PER_FRAME_DEF,
    parameter int unsigned FRAME_MODULUS       = swts_pkg::FRAME_MODULUS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [swts_pkg::CFG_W-1:0]          cfg_wr_data,
    input  logic [swts_pkg::S_DATA_W-1:0]       s_tdata,
    input  logic                                s_tuser,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [swts_pkg::SUM_W-1:0]          m_tdata,
    output logic [swts_pkg::STATUS_W-1:0]       m_tuser,
    input  swts_pkg::swts_cmd_t                 cmd,
    output swts_pkg::swts_sts_t                 sts
);
    import swts_pkg::*;

    localparam int unsigned RING_DEPTH = WINDOW_FRAMES * MAX_TICKS_PER_FRAME;
    localparam int unsigned POS_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [POS_W-1:0] CLEAR_LAST = POS_W'(RING_DEPTH - 1);
    localparam logic [TPF_W-1:0] TPF_RST    = sat_tpf(CFG_W'(TPF_RESET),
                                                      MAX_TICKS_PER_FRAME);
    localparam logic [POS_W-1:0] LAST_RST   = POS_W'(WINDOW_FRAMES * TPF_RST - 1);

    logic [SUM_W-1:0] ring_mem [RING_DEPTH];

    logic                  op_reg;
    logic [FRAME_W-1:0]    frame_reg;
    logic [TICK_W-1:0]     tick_reg;
    logic [AMOUNT_W-1:0]   amount_reg;

    logic [TPF_W-1:0]      tpf_reg;
    logic [POS_W-1:0]      ring_last_reg;
    logic [SUM_W-1:0]      total_reg;
    logic [POS_W-1:0]      wp_reg;
    logic [FRAME_W-1:0]    cur_frame_reg;
    logic [TICK_W-1:0]     cur_tick_reg;
    logic [POS_W-1:0]      clr_cnt_reg;
    logic [SUM_W-1:0]      rdata_reg;

    logic                  m_valid_reg;
    logic [STATUS_W-1:0]   m_status_reg;
    logic [SUM_W-1:0]      m_total_reg;

    logic [TPF_W-1:0]      cfg_tpf;
    logic [POS_W-1:0]      next_pos;
    logic [TPF_W-1:0]      tick_inc;
    logic [FRAME_W:0]      frame_inc;
    logic [SUM_W-1:0]      amount_ext;
    logic                  pos_match;
    logic                  tick_valid;
    logic                  mem_we;
    logic [POS_W-1:0]      mem_waddr;
    logic [SUM_W-1:0]      mem_wdata;
    logic                  mem_re;
    logic [POS_W-1:0]      mem_raddr;

    assign cfg_tpf    = sat_tpf(cfg_wr_data, MAX_TICKS_PER_FRAME);
    assign next_pos   = (wp_reg == ring_last_reg) ? '0 : wp_reg + POS_W'(1);
    assign tick_inc   = {1'b0, cur_tick_reg} + TPF_W'(1);
    assign frame_inc  = {1'b0, cur_frame_reg} + (FRAME_W+1)'(1);
    assign amount_ext = {{(SUM_W-AMOUNT_W){1'b0}}, amount_reg};
    assign pos_match  = (frame_reg == cur_frame_reg) && (tick_reg == cur_tick_reg);
    assign tick_valid = ({1'b0, tick_reg} < tpf_reg)
                     && ({1'b0, frame_reg} < (FRAME_W+1)'(FRAME_MODULUS));

    assign sts.clear_done = (clr_cnt_reg == CLEAR_LAST);
    assign sts.is_data    = !op_reg;
    assign sts.pos_match  = pos_match;
    assign sts.tick_valid = tick_valid;
    assign sts.out_free   = !m_valid_reg || m_tready;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = wp_reg;
        mem_wdata = '0;
        priority if (cmd.clear_step) begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
        end else if (cmd.data_wr) begin
            mem_we    = 1'b1;
            mem_wdata = rdata_reg + amount_ext;
        end else if (cmd.step_wr) begin
            mem_we    = 1'b1;
            mem_waddr = next_pos;
        end else begin
            mem_we    = 1'b0;
        end
        mem_re    = cmd.rd_cur || cmd.rd_next;
        mem_raddr = cmd.rd_next ? next_pos : wp_reg;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= ring_mem[mem_raddr];
        end
    end

    // input word and result payload
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            op_reg     <= s_tuser;
            frame_reg  <= s_tdata[FRAME_W-1:0];
            tick_reg   <= s_tdata[FRAME_W +: TICK_W];
            amount_reg <= s_tdata[FRAME_W+TICK_W +: AMOUNT_W];
        end
        if (cmd.load_result) begin
            m_total_reg <= '0;
            if (op_reg) begin
                if (tick_valid) begin
                    m_status_reg <= ST_TICK_REPORTED;
                    m_total_reg  <= total_reg;
                end else begin
                    m_status_reg <= ST_TICK_REJECTED;
                end
            end else begin
                m_status_reg <= pos_match ? ST_DATA_ADDED : ST_DATA_DROPPED;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpf_reg       <= TPF_RST;
            ring_last_reg <= LAST_RST;
            total_reg     <= '0;
            wp_reg        <= '0;
            cur_frame_reg <= '0;
            cur_tick_reg  <= '0;
            clr_cnt_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.load_result) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            priority if (cfg_wr_en) begin
                tpf_reg       <= cfg_tpf;
                ring_last_reg <= POS_W'(WINDOW_FRAMES * cfg_tpf - 1);
                total_reg     <= '0;
                wp_reg        <= '0;
                cur_frame_reg <= '0;
                cur_tick_reg  <= '0;
                clr_cnt_reg   <= '0;
            end else if (cmd.clear_step) begin
                if (clr_cnt_reg != CLEAR_LAST) begin
                    clr_cnt_reg <= clr_cnt_reg + POS_W'(1);
                end
            end else if (cmd.data_wr) begin
                total_reg <= total_reg + amount_ext;
            end else if (cmd.step_wr) begin
                // enter the next bucket: drop its count from the total
                wp_reg    <= next_pos;
                total_reg <= total_reg - rdata_reg;
                if (tick_inc >= tpf_reg) begin
                    cur_tick_reg <= '0;
                    if (frame_inc >= (FRAME_W+1)'(FRAME_MODULUS)) begin
                        cur_frame_reg <= '0;
                    end else begin
                        cur_frame_reg <= frame_inc[FRAME_W-1:0];
                    end
                end else begin
                    cur_tick_reg <= tick_inc[TICK_W-1:0];
                end
            end else begin
                total_reg <= total_reg;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_total_reg;
    assign m_tuser  = m_status_reg;

endmodule

@@ design/sliding_window_throughput_sum_unit.sv @@
// Channel  | Direction | Handshake          | Contents
// s_       | in        | s_tvalid/s_tready  | tdata: frame, tick, amount; tuser: op
// m_       | out       | m_tvalid/m_tready  | tdata: window total; tuser: status
// cfg_     | in        | cfg_wr_en          | ticks per frame, no read-back
//
// One word is in work at a time. A mismatched data word or a rejected tick
// goes back to idle after evaluation, an added data word does a bucket read,
// then a write back, and a tick word steps one tick at a time, each step
// being one read and one write on the single-port bucket memory.
// After reset and after every config write a clearing pass zeroes all
// WINDOW_FRAMES*MAX_TICKS_PER_FRAME buckets (2000 buckets by default), with
// s_tready low. A stalled result waits in the output register while the next
// word is taken in.
module sliding_window_throughput_sum_unit #(
    parameter int unsigned WINDOW_FRAMES       = swts_pkg::WINDOW_FRAMES_DEF,
    parameter int unsigned MAX_TICKS_PER_FRAME = swts_pkg::MAX_TICKS_PER_FRAME_DEF,
    parameter int unsigned FRAME_MODULUS       = swts_pkg::FRAME_MODULUS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [swts_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [swts_pkg::S_DATA_W-1:0]  s_tdata,  // frame_number, tick_index, amount, 0
    input  logic                           s_tuser,  // op
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [swts_pkg::SUM_W-1:0]     m_tdata,  // window_total
    output logic [swts_pkg::STATUS_W-1:0]  m_tuser   // status
);
    import swts_pkg::*;

    swts_cmd_t cmd;
    swts_sts_t sts;

    swts_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .cfg_wr_en (cfg_wr_en),
        .sts       (sts),
        .cmd       (cmd),
        .s_tready  (s_tready)
    );

    swts_datapath #(
        .WINDOW_FRAMES       (WINDOW_FRAMES),
        .MAX_TICKS_PER_FRAME (MAX_TICKS_PER_FRAME),
        .FRAME_MODULUS       (FRAME_MODULUS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

@@ design/swts_checker.sv @@
module swts_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           cfg_wr_en,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [swts_pkg::SUM_W-1:0]     m_tdata,
    input logic [swts_pkg::STATUS_W-1:0]  m_tuser
);
    import swts_pkg::*;

    // stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

    // only a tick report carries a total
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_TICK_REPORTED) |-> m_tdata == '0)
        else $error("nonzero total on non-report word");

    // one word in work at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken back to back");

    // config write starts the clearing pass
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_tready)
        else $error("input ready right after config write");

endmodule

bind sliding_window_throughput_sum_unit swts_checker u_swts_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_wr_en (cfg_wr_en),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import swts_pkg::*;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam int unsigned RING_DEPTH    = WINDOW_FRAMES_DEF * MAX_TICKS_PER_FRAME_DEF;
    localparam int unsigned PHASE_ITEMS   = 185;
    localparam int unsigned NUM_PHASES    = 6;
    localparam int          CYCLE_LIMIT   = 2_000_000;
    localparam int          TAIL_CYCLES   = 20;

    typedef struct {
        logic                op;
        logic [FRAME_W-1:0]  frame;
        logic [TICK_W-1:0]   tick;
        logic [AMOUNT_W-1:0] amount;
    } win_item_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [SUM_W-1:0]    total;
    } window_result_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata     = '0;  // frame_number, tick_index, amount, 0
    logic                 s_tuser     = 1'b0;  // op
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [SUM_W-1:0]     m_tdata;  // window_total
    logic [STATUS_W-1:0]  m_tuser;  // status

    sliding_window_throughput_sum_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    win_item_t      pending_words[$];
    window_result_t expected_results[$];
    win_item_t      held_word;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int err_count     = 0;
    int cycle_count   = 0;

    // Window model
    logic [CFG_W-1:0] model_tpf;
    logic [SUM_W-1:0] bucket_sums [0:RING_DEPTH-1];
    logic [SUM_W-1:0] window_sum;
    int unsigned      model_wpos;
    int unsigned      model_frame;
    int unsigned      model_tick;

    // Stimulus-side position tracking
    int unsigned gen_tpf;
    int unsigned gen_frame;
    int unsigned gen_tick;

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic int unsigned effective_tpf(input logic [CFG_W-1:0] v);
        if (v == '0) return 1;
        if (v > MAX_TICKS_PER_FRAME_DEF) return MAX_TICKS_PER_FRAME_DEF;
        return 32'(v);
    endfunction

    task automatic restart_window(input logic [CFG_W-1:0] v);
        model_tpf = v;
        for (int i = 0; i < RING_DEPTH; i++) bucket_sums[i] = '0;
        window_sum  = '0;
        model_wpos  = 0;
        model_frame = 0;
        model_tick  = 0;
        gen_tpf     = effective_tpf(v);
        gen_frame   = 0;
        gen_tick    = 0;
    endtask

    task automatic predict_window(input win_item_t it);
        int unsigned    tpf_eff;
        int unsigned    ring_len;
        window_result_t res;
        tpf_eff  = effective_tpf(model_tpf);
        ring_len = WINDOW_FRAMES_DEF * tpf_eff;
        res.total = '0;
        if (it.op == OP_DATA) begin
            if (it.frame != model_frame || it.tick != model_tick) begin
                res.status = ST_DATA_DROPPED;
            end else begin
                bucket_sums[model_wpos] = bucket_sums[model_wpos] + SUM_W'(it.amount);
                window_sum = window_sum + SUM_W'(it.amount);
                res.status = ST_DATA_ADDED;
            end
        end else if (it.tick >= tpf_eff) begin
            res.status = ST_TICK_REJECTED;
        end else begin
            res.status = ST_TICK_REPORTED;
            res.total  = window_sum;
            // step one tick at a time, expiring each bucket entered
            while (model_frame != it.frame || model_tick != it.tick) begin
                model_wpos = (model_wpos + 1 >= ring_len) ? 0 : model_wpos + 1;
                window_sum = window_sum - bucket_sums[model_wpos];
                bucket_sums[model_wpos] = '0;
                if (model_tick + 1 >= tpf_eff) begin
                    model_tick  = 0;
                    model_frame = (model_frame + 1 >= FRAME_MODULUS_DEF) ? 0 : model_frame + 1;
                end else begin
                    model_tick = model_tick + 1;
                end
            end
        end
        expected_results.push_back(res);
    endtask

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic push_data(input int unsigned frame, input int unsigned tick,
                             input logic [AMOUNT_W-1:0] amount);
        win_item_t it;
        it.op     = OP_DATA;
        it.frame  = FRAME_W'(frame);
        it.tick   = TICK_W'(tick);
        it.amount = amount;
        pending_words.push_back(it);
    endtask

    task automatic push_tick(input int unsigned frame, input int unsigned tick);
        win_item_t it;
        it.op     = OP_TICK;
        it.frame  = FRAME_W'(frame);
        it.tick   = TICK_W'(tick);
        it.amount = $urandom();
        pending_words.push_back(it);
        if (tick < gen_tpf) begin
            gen_frame = frame;
            gen_tick  = tick;
        end
    endtask

    task automatic advance_ticks(input int unsigned steps);
        int unsigned idx;
        idx = gen_frame * gen_tpf + gen_tick;
        idx = (idx + steps) % (FRAME_MODULUS_DEF * gen_tpf);
        push_tick(idx / gen_tpf, idx % gen_tpf);
    endtask

    // the block is idle only once it takes input again after the last result
    task automatic wait_idle();
        while (pending_words.size() != 0 || s_tvalid || expected_results.size() != 0
               || !s_tready)
            @(negedge aclk);
    endtask

    task automatic write_tpf(input logic [CFG_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        restart_window(v);
    endtask

    task automatic push_random_item();
        int unsigned r;
        int unsigned sel;
        logic [AMOUNT_W-1:0] amt;
        r   = $urandom_range(99);
        sel = $urandom_range(99);
        if (r < 45) begin
            amt = (sel < 10) ? '1 : (sel < 15) ? '0 : AMOUNT_W'($urandom());
            push_data(gen_frame, gen_tick, amt);
        end else if (r < 75) begin
            if (sel < 70)      advance_ticks(1);
            else if (sel < 95) advance_ticks($urandom_range(30));
            else               advance_ticks($urandom_range(WINDOW_FRAMES_DEF * gen_tpf + 50, 31));
        end else if (r < 90) begin
            push_data($urandom_range(FRAME_MODULUS_DEF - 1), $urandom_range(31), $urandom());
        end else begin
            push_tick($urandom_range(FRAME_MODULUS_DEF - 1), $urandom_range(31, gen_tpf));
        end
    endtask

    // Driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_window(held_word);
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    held_word = pending_words.pop_front();
                    s_tdata  <= {1'b0, held_word.amount, held_word.tick, held_word.frame};
                    s_tuser  <= held_word.op;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge aclk) begin
        window_result_t exp;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected word status=%0d total=%0h",
                                              m_tuser, m_tdata));
                end else begin
                    exp = expected_results.pop_front();
                    if (m_tuser !== exp.status)
                        report_mismatch($sformatf("status %0d, predicted %0d",
                                                  m_tuser, exp.status));
                    if (m_tdata !== exp.total)
                        report_mismatch($sformatf("window_total %0h, predicted %0h",
                                                  m_tdata, exp.total));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        logic [CFG_W-1:0] phase_cfg [NUM_PHASES];
        phase_cfg[0] = 5'd0;
        phase_cfg[1] = 5'd20;
        phase_cfg[2] = 5'd31;
        phase_cfg[3] = 5'd1;
        phase_cfg[4] = 5'd7;
        phase_cfg[5] = CFG_W'($urandom_range(19, 2));

        restart_window(CFG_W'(TPF_RESET));
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset value of ticks per frame
        push_data(0, 0, '1);
        push_data(0, 0, '0);
        push_data(1, 0, $urandom());
        push_data(0, 1, $urandom());
        push_data(FRAME_MODULUS_DEF - 1, 31, '1);
        push_tick(0, 0);
        advance_ticks(1);
        push_data(gen_frame, gen_tick, '1);
        push_tick(5, gen_tpf);
        push_tick(FRAME_MODULUS_DEF - 1, 31);
        // expire the first bucket by going once around the ring
        advance_ticks(WINDOW_FRAMES_DEF * gen_tpf - 1);
        advance_ticks(1);
        push_data(gen_frame, gen_tick, $urandom());
        // catch up through every frame back to one tick behind
        advance_ticks(FRAME_MODULUS_DEF * gen_tpf - 1);
        push_tick(gen_frame, gen_tick);
        push_data(gen_frame, gen_tick, 32'h8000_0000);
        advance_ticks(500);
        push_data(gen_frame, gen_tick, '1);
        push_data(gen_frame, gen_tick, $urandom());
        advance_ticks(1);
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < 2) begin
                send_idle_pct = 12;
                recv_idle_pct = 68;
            end else if (p < 4) begin
                send_idle_pct = 68;
                recv_idle_pct = 12;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            repeat (4) @(posedge aclk);
            write_tpf(phase_cfg[p]);
            push_tick(gen_frame, gen_tpf);
            if (gen_tpf == MAX_TICKS_PER_FRAME_DEF && p == 1)
                advance_ticks(FRAME_MODULUS_DEF * gen_tpf - 1);
            for (int i = 0; i < PHASE_ITEMS; i++) push_random_item();
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
